FILE: rtl/core/gdd_pkg.sv
// Package with shared widths, constants, month tables and pipeline enable type.
`timescale 1ns / 1ps

package gdd_pkg;

	// Field widths of one date.
	localparam int unsigned DayW   = 5;
	localparam int unsigned MonthW = 4;
	localparam int unsigned YearW  = 14;

	// Day counts since year 1 fit in 23 bits for every 14-bit year.
	localparam int unsigned CountW = 23;
	localparam int unsigned DaysW  = 23;

	// Largest positive day difference that the signed result can hold.
	localparam logic [DaysW-1:0] DaysMaxPos = {1'b0, {(DaysW-1){1'b1}}};

	// Months of the year.
	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;

	// Reciprocal of 100 scaled by 2^19; exact for every 14-bit year.
	localparam int unsigned Recip100Shift = 19;
	localparam logic [12:0] Recip100      = 13'd5243;
	localparam int unsigned ProdW         = YearW + 13;
	localparam int unsigned Q100W         = 8;

	// Stage load enables of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// Length of a month; codes outside 1..12 give zero.
	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DayW-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days of the months before month m in a common year.
	function automatic logic [8:0] cum_days(input logic [MonthW-1:0] m);
		logic [8:0] days;
		case (m)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

FILE: rtl/core/gregorian_date_difference_top.sv
// Each item goes through the stage registers s1 to s4 in turn, two date lanes side by side.
// Throughput: one item per cycle while the output is not held back.
// A stage loads whenever it is empty or the stage after it moves on.
// Reset (arst_n low) clears the stage valid bits at once; the payload is not reset.
// Each input transfer gives exactly one output transfer.
`timescale 1ns / 1ps

module gregorian_date_difference_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// first_day[4:0], first_month[8:5], first_year[22:9],
	// second_day[27:23], second_month[31:28], second_year[45:32], zeros[47:46]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// days_between[22:0], zero[23]
	output logic [23:0] m_tdata,
	// first_ok[0], second_ok[1]
	output logic [1:0]  m_tuser
);

	logic                              v_s1_q, v_s2_q, v_s3_q, v_s4_q;
	logic                              rdy1, rdy2, rdy3, rdy4;
	gdd_pkg::pipe_en_t                 en;
	logic                              ok1, ok2;
	logic [gdd_pkg::CountW-1:0]        cnt1, cnt2;
	logic                              first_ok, second_ok;
	logic signed [gdd_pkg::DaysW-1:0]  days_between;

	// Each stage may load when it is empty or its contents move on.
	assign rdy4     = !v_s4_q || m_tready;
	assign rdy3     = !v_s3_q || rdy4;
	assign rdy2     = !v_s2_q || rdy3;
	assign rdy1     = !v_s1_q || rdy2;
	assign s_tready = rdy1;
	assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else begin
			if (rdy1) v_s1_q <= s_tvalid;
			if (rdy2) v_s2_q <= v_s1_q;
			if (rdy3) v_s3_q <= v_s2_q;
			if (rdy4) v_s4_q <= v_s3_q;
		end
	end

	// Lane for the first date.
	gdd_lane u_lane_first (
		.clk   (clk),
		.en    (en),
		.day   (s_tdata[4:0]),
		.month (s_tdata[8:5]),
		.year  (s_tdata[22:9]),
		.ok    (ok1),
		.count (cnt1)
	);

	// Lane for the second date.
	gdd_lane u_lane_second (
		.clk   (clk),
		.en    (en),
		.day   (s_tdata[27:23]),
		.month (s_tdata[31:28]),
		.year  (s_tdata[45:32]),
		.ok    (ok2),
		.count (cnt2)
	);

	// Merge of the two lane results.
	gdd_merge u_merge (
		.clk          (clk),
		.en           (en),
		.first_ok_in  (ok1),
		.second_ok_in (ok2),
		.first_count  (cnt1),
		.second_count (cnt2),
		.first_ok     (first_ok),
		.second_ok    (second_ok),
		.days_between (days_between)
	);

	assign m_tvalid = v_s4_q;
	assign m_tdata  = {1'b0, days_between};
	assign m_tuser  = {second_ok, first_ok};

	// The input side only stalls when a finished result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// The second date is never reported valid unless the first one is.
	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
		else $error("second_ok set while first_ok clear");

	// An invalid pair always reports a zero difference.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata == '0))
		else $error("nonzero difference for an invalid pair");

	// A new result only appears when stage three held an item.
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s4_q) |-> $past(v_s3_q))
		else $error("output valid without an item in stage three");

endmodule

FILE: rtl/core/gdd_lane.sv
// One date lane: checks a date and turns it into a day count since year 1.
`timescale 1ns / 1ps

module gdd_lane (
	input  logic                               clk,
	input  gdd_pkg::pipe_en_t                  en,
	input  logic [gdd_pkg::DayW-1:0]           day,
	input  logic [gdd_pkg::MonthW-1:0]         month,
	input  logic [gdd_pkg::YearW-1:0]          year,
	output logic                               ok,
	output logic [gdd_pkg::CountW-1:0]         count
);

	logic [gdd_pkg::DayW-1:0]   day_s1;
	logic [gdd_pkg::MonthW-1:0] month_s1;
	logic [gdd_pkg::YearW-1:0]  year_s1;
	logic [gdd_pkg::Q100W-1:0]  q100_s1;
	logic [gdd_pkg::ProdW-1:0]  prod;
	logic [gdd_pkg::YearW-1:0]  rem100;
	logic                       leap;
	logic                       month_ok;
	logic                       valid;
	logic [gdd_pkg::CountW-1:0] total;
	logic                       ok_s2;
	logic [gdd_pkg::CountW-1:0] count_s2;

	// Stage 1: year divided by 100 through a reciprocal multiply.
	assign prod = gdd_pkg::ProdW'(year) * gdd_pkg::ProdW'(gdd_pkg::Recip100);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			q100_s1  <= prod[gdd_pkg::Recip100Shift +: gdd_pkg::Q100W];
		end
	end

	// Stage 2: leap rule, validity and closed-form day count.
	always_comb begin
		rem100   = year_s1 - gdd_pkg::YearW'(q100_s1) * gdd_pkg::YearW'(100);
		leap     = ((year_s1[1:0] == 2'b00) && (rem100 != '0)) ||
		           ((rem100 == '0) && (q100_s1[1:0] == 2'b00));
		month_ok = (month_s1 >= gdd_pkg::MonthJan) && (month_s1 <= gdd_pkg::MonthDec);
		valid    = (year_s1 != '0) && month_ok && (day_s1 != '0) &&
		           (day_s1 <= gdd_pkg::month_days(month_s1, leap));
		total    = gdd_pkg::CountW'(year_s1) * gdd_pkg::CountW'(365)
		         + gdd_pkg::CountW'(year_s1 >> 2)
		         - gdd_pkg::CountW'(q100_s1)
		         + gdd_pkg::CountW'(q100_s1 >> 2)
		         + gdd_pkg::CountW'(gdd_pkg::cum_days(month_s1))
		         + gdd_pkg::CountW'(leap && (month_s1 > gdd_pkg::MonthFeb))
		         + gdd_pkg::CountW'(day_s1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ok_s2    <= valid;
			count_s2 <= total;
		end
	end

	assign ok    = ok_s2;
	assign count = count_s2;

endmodule

FILE: rtl/core/gdd_merge.sv
// Merge stage: combines the two lane counts into the clamped day difference.
`timescale 1ns / 1ps

module gdd_merge (
	input  logic                              clk,
	input  gdd_pkg::pipe_en_t                 en,
	input  logic                              first_ok_in,
	input  logic                              second_ok_in,
	input  logic [gdd_pkg::CountW-1:0]        first_count,
	input  logic [gdd_pkg::CountW-1:0]        second_count,
	output logic                              first_ok,
	output logic                              second_ok,
	output logic signed [gdd_pkg::DaysW-1:0]  days_between
);

	logic                       first_ok_s3;
	logic                       second_ok_s3;
	logic [gdd_pkg::CountW-1:0] diff_s3;
	logic [gdd_pkg::CountW-1:0] diff_m1;
	logic [gdd_pkg::DaysW-1:0]  result;
	logic                       first_ok_s4;
	logic                       second_ok_s4;
	logic [gdd_pkg::DaysW-1:0]  days_s4;

	// Stage 3: absolute difference; the second flag needs both dates valid.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			first_ok_s3  <= first_ok_in;
			second_ok_s3 <= first_ok_in && second_ok_in;
			diff_s3      <= (second_count >= first_count) ?
			                (second_count - first_count) : (first_count - second_count);
		end
	end

	// Stage 4: zero for an invalid pair, else minus one, equal dates give all ones, large values saturate.
	always_comb begin
		diff_m1 = diff_s3 - gdd_pkg::CountW'(1);
		if (!second_ok_s3) begin
			result = '0;
		end else if (diff_s3 == '0) begin
			result = '1;
		end else if (diff_m1 > gdd_pkg::DaysMaxPos) begin
			result = gdd_pkg::DaysMaxPos;
		end else begin
			result = diff_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			first_ok_s4  <= first_ok_s3;
			second_ok_s4 <= second_ok_s3;
			days_s4      <= result;
		end
	end

	assign first_ok     = first_ok_s4;
	assign second_ok    = second_ok_s4;
	assign days_between = days_s4;

endmodule

FILE: bench/tb_gregorian_date_difference_top.sv
// Self-checking testbench for the Gregorian date difference block.
`timescale 1ns / 1ps

module tb_gregorian_date_difference_top;

	// Cycles with no transfer on either side before the run is called hung.
	localparam int unsigned QuietLimit = 2000;
	// Length of the forced receiver hold-off in the back-pressure test.
	localparam int unsigned HoldOffCycles = 400;

	// One calendar date, packed with the day in the lowest bits as on the bus.
	typedef struct packed {
		logic [gdd_pkg::YearW-1:0]  year;
		logic [gdd_pkg::MonthW-1:0] month;
		logic [gdd_pkg::DayW-1:0]   day;
	} date_t;

	localparam int unsigned DateW = $bits(date_t);

	// One result as it should appear on the output port.
	typedef struct packed {
		logic                      first_ok;
		logic                      second_ok;
		logic [gdd_pkg::DaysW-1:0] days_between;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	span_t       expected_spans[$];
	int unsigned error_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold_request = 0;

	gregorian_date_difference_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Calendar arithmetic used to predict each result.
	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(int unsigned m, int unsigned y);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic bit date_ok(date_t d);
		if (d.year == 0 || d.month < 1 || d.month > 12 || d.day == 0)
			return 1'b0;
		return d.day <= month_length(d.month, d.year);
	endfunction

	// Days of years 1 through the date's year, plus the whole months before
	// it, plus the day itself.
	function automatic int unsigned day_number(date_t d);
		int unsigned total;
		total = 365 * d.year + d.year / 4 - d.year / 100 + d.year / 400;
		for (int unsigned j = 1; j < d.month; j++)
			total += month_length(j, d.year);
		return total + d.day;
	endfunction

	function automatic span_t predict_span(date_t a, date_t b);
		span_t       s;
		int unsigned ca;
		int unsigned cb;
		int unsigned gap;
		s = '0;
		s.first_ok = date_ok(a);
		s.second_ok = s.first_ok && date_ok(b);
		if (s.second_ok) begin
			ca = day_number(a);
			cb = day_number(b);
			gap = (cb >= ca) ? cb - ca : ca - cb;
			if (gap == 0)
				s.days_between = '1;
			else if (gap - 1 > gdd_pkg::DaysMaxPos)
				s.days_between = gdd_pkg::DaysMaxPos;
			else
				s.days_between = gdd_pkg::DaysW'(gap - 1);
		end
		return s;
	endfunction

	function automatic date_t make_date(int unsigned d, int unsigned m, int unsigned y);
		date_t r;
		r.day = gdd_pkg::DayW'(d);
		r.month = gdd_pkg::MonthW'(m);
		r.year = gdd_pkg::YearW'(y);
		return r;
	endfunction

	// Mostly short gaps, some medium, a few long ones.
	function automatic int unsigned gap_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 3);
		if (pick < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A valid date with years weighted toward the interesting leap cases.
	function automatic date_t random_valid_date();
		int unsigned y;
		int unsigned m;
		date_t       r;
		case ($urandom_range(0, 9))
			0:       y = $urandom_range(1, 16383);
			1:       y = $urandom_range(1, 163) * 100;
			2:       y = $urandom_range(1, 8);
			default: y = $urandom_range(1, 9999);
		endcase
		m = $urandom_range(1, 12);
		r.year = gdd_pkg::YearW'(y);
		r.month = gdd_pkg::MonthW'(m);
		if ($urandom_range(0, 3) == 0)
			r.day = gdd_pkg::DayW'(month_length(m, y));
		else
			r.day = gdd_pkg::DayW'($urandom_range(1, month_length(m, y)));
		return r;
	endfunction

	// Spoils one field of a valid date so that it fails validation.
	function automatic date_t break_date(date_t d);
		date_t r;
		r = d;
		case ($urandom_range(0, 4))
			0:       r.day = '0;
			1:       r.day = gdd_pkg::DayW'(month_length(d.month, d.year) + 1);
			2:       r.month = '0;
			3:       r.month = gdd_pkg::MonthW'($urandom_range(13, 15));
			default: r.year = '0;
		endcase
		return r;
	endfunction

	// Offers one date pair and returns at the edge where the transfer happens.
	task automatic send_pair(date_t a, date_t b);
		s_tdata <= {2'b00, b, a};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		expected_spans.push_back(predict_span(a, b));
	endtask

	// Random sender gap after a transfer.
	task automatic tx_pause();
		int unsigned n;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			n = gap_length();
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Sender goes quiet until every outstanding result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_spans.size() != 0);
	endtask

	task automatic test_directed_cases();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_pair(make_date(1, 1, 1), make_date(1, 1, 1));
		send_pair(make_date(1, 1, 1), make_date(31, 12, 9999));
		send_pair(make_date(1, 1, 1), make_date(31, 12, 16383));
		send_pair(make_date(31, 12, 16383), make_date(1, 1, 1));
		send_pair(make_date(29, 2, 2000), make_date(1, 3, 2000));
		send_pair(make_date(29, 2, 2024), make_date(1, 1, 2024));
		send_pair(make_date(29, 2, 1900), make_date(1, 1, 1900));
		send_pair(make_date(1, 1, 2023), make_date(29, 2, 2023));
		send_pair(make_date(29, 2, 2100), make_date(28, 2, 2100));
		send_pair(make_date(28, 2, 2023), make_date(1, 3, 2023));
		send_pair(make_date(5, 0, 2000), make_date(5, 5, 2000));
		send_pair(make_date(5, 13, 2000), make_date(5, 5, 2000));
		send_pair(make_date(5, 5, 2000), make_date(5, 15, 2000));
		send_pair(make_date(5, 5, 2000), make_date(0, 5, 2000));
		send_pair(make_date(31, 4, 2000), make_date(1, 1, 2000));
		send_pair(make_date(31, 12, 2000), make_date(31, 1, 2001));
		send_pair(make_date(1, 1, 0), make_date(1, 1, 1));
		send_pair(make_date(1, 1, 1), make_date(1, 1, 0));
		send_pair(make_date(0, 0, 0), make_date(31, 15, 16383));
		send_pair(make_date(31, 12, 1999), make_date(1, 1, 2000));
		send_pair(make_date(29, 2, 16000), make_date(29, 2, 16000));
		send_pair(make_date(30, 9, 1234), make_date(31, 11, 1234));
		wait_drained();
	endtask

	// Well-formed pairs with random content, some near each other, some broken.
	task automatic test_random_pairs(int unsigned count);
		date_t a;
		date_t b;
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		repeat (count) begin
			a = random_valid_date();
			case ($urandom_range(0, 9))
				0: b = a;
				1, 2: begin
					b = a;
					b.day = gdd_pkg::DayW'($urandom_range(1, month_length(a.month, a.year)));
				end
				3: begin
					b = random_valid_date();
					b.year = a.year;
					if (!date_ok(b))
						b.day = gdd_pkg::DayW'(28);
				end
				default: b = random_valid_date();
			endcase
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) == 0)
					a = break_date(a);
				else
					b = break_date(b);
			end
			send_pair(a, b);
			tx_pause();
		end
		wait_drained();
	endtask

	// Raw random fields over their full widths.
	task automatic test_random_fields(int unsigned count);
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		repeat (count) begin
			send_pair(date_t'(DateW'($urandom)), date_t'(DateW'($urandom)));
			tx_pause();
		end
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure(int unsigned count);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_request = HoldOffCycles;
		repeat (count) send_pair(random_valid_date(), random_valid_date());
		wait_drained();
	endtask

	// Back-to-back transfers on both sides with no idling at all.
	task automatic test_full_rate(int unsigned count);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (count) send_pair(random_valid_date(), random_valid_date());
		wait_drained();
	endtask

	// Bursts separated by a full drain of the pipeline.
	task automatic test_drain_pause(int unsigned bursts);
		tx_idle_pct = 10;
		rx_idle_pct = 10;
		repeat (bursts) begin
			repeat ($urandom_range(1, 20)) begin
				send_pair(random_valid_date(), random_valid_date());
				tx_pause();
			end
			wait_drained();
		end
	endtask

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_request != 0) begin
				stall_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (stall_left == 0 && $urandom_range(0, 99) < rx_idle_pct)
				stall_left = gap_length();
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare every output transfer with the oldest prediction.
	always @(posedge clk) begin : check_results
		span_t want;
		if (m_tvalid && m_tready) begin
			if (expected_spans.size() == 0) begin
				$error("result transfer with no prediction waiting: tdata %h tuser %b",
						m_tdata, m_tuser);
				error_count++;
			end else begin
				want = expected_spans.pop_front();
				if (m_tuser[0] !== want.first_ok) begin
					$error("first_ok: expected %0d, actual %b", want.first_ok, m_tuser[0]);
					error_count++;
				end
				if (m_tuser[1] !== want.second_ok) begin
					$error("second_ok: expected %0d, actual %b", want.second_ok, m_tuser[1]);
					error_count++;
				end
				if (m_tdata[gdd_pkg::DaysW-1:0] !== want.days_between) begin
					$error("days_between: expected %0d, actual %0d",
							$signed(want.days_between), $signed(m_tdata[gdd_pkg::DaysW-1:0]));
					error_count++;
				end
				if (m_tdata[23] !== 1'b0) begin
					$error("tdata pad bit: expected 0, actual %b", m_tdata[23]);
					error_count++;
				end
			end
		end
	end

	// Hang detection: too many cycles in a row without any transfer.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("gregorian_date_difference_top test failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_pairs(880);
		test_random_fields(300);
		test_backpressure(60);
		test_full_rate(70);
		test_drain_pause(3);
		// Let any stray result show up before the verdict.
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_spans.size() == 0) begin
			$display("gregorian_date_difference_top test passed");
		end else begin
			$display("gregorian_date_difference_top test failed");
		end
		$finish;
	end

endmodule
